### design/aes_ofb_pkg.sv
// shared types, constants and byte functions for the aes ofb stream cipher
package aes_ofb_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int BLOCK_BITS = 128;
  localparam int RK_ENTRIES = 16;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_MODE = 3'd0,
    REG_KEY_W0   = 3'd1,
    REG_KEY_W1   = 3'd2,
    REG_KEY_W2   = 3'd3,
    REG_KEY_W3   = 3'd4,
    REG_IV_HIGH  = 3'd5,
    REG_IV_LOW   = 3'd6
  } cfg_reg_t;

  // how an item uses the keystream
  typedef enum logic [1:0] {
    KIND_CONT    = 2'd0,
    KIND_NEWBLK  = 2'd1,
    KIND_RESTART = 2'd2
  } item_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    item_kind_t kind;
    logic [3:0] pos;
  } item_t;

  typedef struct packed {
    logic start;
    logic flush;
  } aes_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aes_rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### design/aes_ofb_stream_cipher.sv
// top level of the aes ofb byte stream cipher
//
//   channel  signals                                   direction
//   cfg      cfg_we, cfg_index, cfg_data               in, write only
//   in       in_valid/in_ready, in_byte, first_byte,   in
//            last_byte
//   out      out_valid/out_ready, out_byte, last_out   out
//
// one item per cycle is sustained within a keystream block while the output
// is not stalled; the next block is encrypted in the background (one aes
// round per cycle) while the 16 bytes of the current one flow, so blocks
// follow without a gap. an item with first_byte waits for the iv encryption.
// after reset, and after any key or key size write, the key schedule is
// rebuilt one word a cycle; items are queued meanwhile.
// reset is synchronous; the input queue keeps taking items while the output
// register is stalled, until the queue fills
module aes_ofb_stream_cipher import aes_ofb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_out
);

  // configuration registers
  logic [1:0]   key_size_mode;
  logic [63:0]  key_word_0;
  logic [63:0]  key_word_1;
  logic [63:0]  key_word_2;
  logic [63:0]  key_word_3;
  logic [63:0]  iv_high;
  logic [63:0]  iv_low;

  // front to back
  logic         head_valid;
  item_t        head;
  logic         pop;

  // key schedule and round engine
  logic         key_write;
  logic [3:0]   rk_addr;
  logic [127:0] rk_q;
  logic [3:0]   nr;
  logic         kx_ready;
  aes_req_t     aes_req;
  aes_rsp_t     aes_rsp;
  logic [127:0] aes_blk;
  logic [127:0] aes_result;

  // a key change rebuilds the schedule and drops any precomputed block
  always_comb begin
    case (cfg_index)
      REG_KEY_MODE, REG_KEY_W0, REG_KEY_W1, REG_KEY_W2, REG_KEY_W3:
        key_write = cfg_we;
      default:
        key_write = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size_mode <= 2'd0;
      key_word_0    <= '0;
      key_word_1    <= '0;
      key_word_2    <= '0;
      key_word_3    <= '0;
      iv_high       <= '0;
      iv_low        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_MODE: key_size_mode <= cfg_data[1:0];
        REG_KEY_W0:   key_word_0    <= cfg_data;
        REG_KEY_W1:   key_word_1    <= cfg_data;
        REG_KEY_W2:   key_word_2    <= cfg_data;
        REG_KEY_W3:   key_word_3    <= cfg_data;
        REG_IV_HIGH:  iv_high       <= cfg_data;
        REG_IV_LOW:   iv_low        <= cfg_data;
        default:      key_size_mode <= key_size_mode;
      endcase
    end
  end

  aes_ofb_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .first_byte(first_byte),
    .last_byte (last_byte),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  aes_ofb_keyexp u_keyexp (
    .clk          (clk),
    .rst          (rst),
    .restart      (key_write),
    .key_size_mode(key_size_mode),
    .key_word_0   (key_word_0),
    .key_word_1   (key_word_1),
    .key_word_2   (key_word_2),
    .key_word_3   (key_word_3),
    .rk_addr      (rk_addr),
    .rk_q         (rk_q),
    .nr           (nr),
    .ready        (kx_ready)
  );

  aes_ofb_rounds u_rounds (
    .clk    (clk),
    .rst    (rst),
    .req    (aes_req),
    .blk    (aes_blk),
    .nr     (nr),
    .rk_q   (rk_q),
    .rk_addr(rk_addr),
    .rsp    (aes_rsp),
    .result (aes_result)
  );

  aes_ofb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .iv_high   (iv_high),
    .iv_low    (iv_low),
    .key_flush (key_write),
    .kx_ready  (kx_ready),
    .aes_req   (aes_req),
    .aes_blk   (aes_blk),
    .aes_rsp   (aes_rsp),
    .aes_result(aes_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_out  (last_out)
  );

endmodule

### design/aes_ofb_front.sv
// input side: accepts items, tags each with its keystream use, queues them
module aes_ofb_front import aes_ofb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       head_valid,
  output item_t      head,
  input  logic       pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  item_t            q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [3:0]       fpos;
  item_t            entry;
  logic             push;

  assign in_ready   = (count != FULL_CNT);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  // classify against the running byte position
  always_comb begin
    entry.data = in_byte;
    entry.last = last_byte;
    if (first_byte) begin
      entry.kind = KIND_RESTART;
      entry.pos  = 4'd0;
    end else if (fpos == 4'd0) begin
      entry.kind = KIND_NEWBLK;
      entry.pos  = 4'd0;
    end else begin
      entry.kind = KIND_CONT;
      entry.pos  = fpos;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      fpos   <= 4'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
        fpos   <= entry.pos + 4'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/aes_ofb_keyexp.sv
// key schedule: expands the key one word a cycle into the round key store
module aes_ofb_keyexp import aes_ofb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         restart,
  input  logic [1:0]   key_size_mode,
  input  logic [63:0]  key_word_0,
  input  logic [63:0]  key_word_1,
  input  logic [63:0]  key_word_2,
  input  logic [63:0]  key_word_3,
  input  logic [3:0]   rk_addr,
  output logic [127:0] rk_q,
  output logic [3:0]   nr,
  output logic         ready
);

  logic [127:0] rk [RK_ENTRIES];
  logic [31:0]  win [8];
  logic         active;
  logic [5:0]   idx;
  logic [2:0]   j;
  logic [7:0]   rcon;
  logic [3:0]   nk;
  logic [2:0]   nk_m1;
  logic [5:0]   idx_end;
  logic [31:0]  w_back;
  logic [31:0]  w_key;
  logic [31:0]  t;
  logic [31:0]  w;
  logic [31:0]  s;
  logic         in_key;
  logic         rot_step;

  always_comb begin
    case (key_size_mode)
      2'd0: begin
        nk = 4'd4; nk_m1 = 3'd3; idx_end = 6'd43; w_back = win[3];
      end
      2'd1: begin
        nk = 4'd6; nk_m1 = 3'd5; idx_end = 6'd51; w_back = win[5];
      end
      default: begin
        nk = 4'd8; nk_m1 = 3'd7; idx_end = 6'd59; w_back = win[7];
      end
    endcase
  end

  assign nr    = nk + 4'd6;
  assign ready = !active;

  always_comb begin
    case (idx[2:0])
      3'd0:    w_key = key_word_0[63:32];
      3'd1:    w_key = key_word_0[31:0];
      3'd2:    w_key = key_word_1[63:32];
      3'd3:    w_key = key_word_1[31:0];
      3'd4:    w_key = key_word_2[63:32];
      3'd5:    w_key = key_word_2[31:0];
      3'd6:    w_key = key_word_3[63:32];
      default: w_key = key_word_3[31:0];
    endcase
  end

  assign in_key   = (idx < {2'b00, nk});
  assign rot_step = !in_key && (j == 3'd0);
  assign s = {sbox(win[0][31:24]), sbox(win[0][23:16]),
              sbox(win[0][15:8]), sbox(win[0][7:0])};

  always_comb begin
    if (rot_step) begin
      t = {s[23:16] ^ rcon, s[15:8], s[7:0], s[31:24]};
    end else if ((nk == 4'd8) && (j == 3'd4)) begin
      t = s;
    end else begin
      t = win[0];
    end
    w = in_key ? w_key : (w_back ^ t);
  end

  always_ff @(posedge clk) begin
    if (active) begin
      rk[idx[5:2]][(2'd3 - idx[1:0]) * 32 +: 32] <= w;
      win[0] <= w;
      for (int k = 1; k < 8; k++) begin
        win[k] <= win[k-1];
      end
    end
    rk_q <= rk[rk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      active <= 1'b1;
      idx    <= 6'd0;
      j      <= 3'd0;
      rcon   <= 8'h01;
    end else if (active) begin
      idx <= idx + 6'd1;
      j   <= (j == nk_m1) ? 3'd0 : j + 3'd1;
      if (rot_step) begin
        rcon <= xtime(rcon);
      end
      if (idx == idx_end) begin
        active <= 1'b0;
      end
    end
  end

endmodule

### design/aes_ofb_rounds.sv
// block encryption engine: one aes round per cycle on a shared round unit
module aes_ofb_rounds import aes_ofb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  aes_req_t     req,
  input  logic [127:0] blk,
  input  logic [3:0]   nr,
  input  logic [127:0] rk_q,
  output logic [3:0]   rk_addr,
  output aes_rsp_t     rsp,
  output logic [127:0] result
);

  logic [127:0] st;
  logic [3:0]   rnd;
  logic         busy;
  logic [127:0] st_next;

  function automatic logic [127:0] sub_shift(input logic [127:0] x);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (r + 4 * c) -: 8] = sbox(x[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] x);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, al;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = x[127 - 32 * c -: 8];
      a1 = x[119 - 32 * c -: 8];
      a2 = x[111 - 32 * c -: 8];
      a3 = x[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      o[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      o[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  // round key for step rnd arrives registered, so ask for rnd + 1
  assign rk_addr = req.start ? 4'd0 : rnd + 4'd1;

  always_comb begin
    if (rnd == 4'd0) begin
      st_next = st ^ rk_q;
    end else if (rnd == nr) begin
      st_next = sub_shift(st) ^ rk_q;
    end else begin
      st_next = mix(sub_shift(st)) ^ rk_q;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = busy && (rnd == nr);
  assign result   = st_next;

  always_ff @(posedge clk) begin
    if (req.start) begin
      st <= blk;
    end else if (busy) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.flush) begin
      busy <= 1'b0;
      rnd  <= 4'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      rnd  <= 4'd0;
    end else if (busy) begin
      rnd <= rnd + 4'd1;
      if (rnd == nr) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### design/aes_ofb_back.sv
// keystream side: holds current and next blocks, schedules encryptions, xors items
module aes_ofb_back import aes_ofb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  item_t        head,
  output logic         pop,
  input  logic [63:0]  iv_high,
  input  logic [63:0]  iv_low,
  input  logic         key_flush,
  input  logic         kx_ready,
  output aes_req_t     aes_req,
  output logic [127:0] aes_blk,
  input  aes_rsp_t     aes_rsp,
  input  logic [127:0] aes_result,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         last_out
);

  logic [127:0] cur;
  logic [127:0] nxt;
  logic         nxt_valid;
  logic         iv_ready;
  logic         job_iv;
  logic         out_free;
  logic         go;
  logic [7:0]   ks;
  logic         iv_done;
  logic         nxt_done;
  logic         need_iv;
  logic         start_iv;
  logic         go_newblk;
  logic         is_restart;

  assign out_free   = !out_valid || out_ready;
  assign is_restart = head_valid && (head.kind == KIND_RESTART);
  assign iv_done    = aes_rsp.done && job_iv;
  assign nxt_done   = aes_rsp.done && !job_iv;
  assign need_iv    = is_restart && !iv_ready && !(aes_rsp.busy && job_iv);

  always_comb begin
    case (head.kind)
      KIND_CONT: begin
        go = head_valid && out_free;
        ks = cur[{~head.pos, 3'b000} +: 8];
      end
      KIND_NEWBLK: begin
        go = head_valid && out_free && nxt_valid;
        ks = nxt[127:120];
      end
      KIND_RESTART: begin
        go = head_valid && out_free && iv_ready;
        ks = cur[127:120];
      end
      default: begin
        go = 1'b0;
        ks = cur[127:120];
      end
    endcase
  end

  assign pop       = go;
  assign go_newblk = go && (head.kind == KIND_NEWBLK);

  // one encryption at a time: the iv job preempts background work
  always_comb begin
    aes_req.flush = key_flush;
    aes_req.start = 1'b0;
    aes_blk       = cur;
    start_iv      = 1'b0;
    if (key_flush) begin
      aes_req.start = 1'b0;
    end else if (iv_done) begin
      aes_req.start = 1'b1;
      aes_blk       = aes_result;
    end else if (need_iv && kx_ready) begin
      aes_req.start = 1'b1;
      aes_blk       = {iv_high, iv_low};
      start_iv      = 1'b1;
    end else if (go_newblk) begin
      aes_req.start = 1'b1;
      aes_blk       = nxt;
    end else if (kx_ready && !aes_rsp.busy && !nxt_valid && !is_restart) begin
      aes_req.start = 1'b1;
      aes_blk       = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_done) begin
      nxt <= aes_result;
    end
    if (go) begin
      out_byte <= head.data ^ ks;
      last_out <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      nxt_valid <= 1'b0;
      iv_ready  <= 1'b0;
      job_iv    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (iv_done) begin
        cur <= aes_result;
      end else if (go_newblk) begin
        cur <= nxt;
      end
      if (key_flush || iv_done || go_newblk) begin
        nxt_valid <= 1'b0;
      end else if (nxt_done) begin
        nxt_valid <= 1'b1;
      end
      if (iv_done) begin
        iv_ready <= 1'b1;
      end else if (go && (head.kind == KIND_RESTART)) begin
        iv_ready <= 1'b0;
      end
      if (aes_req.start) begin
        job_iv <= start_iv;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
